// ===== hw/rtl/stt_pkg.sv =====
// Shared types and constants of the source text tokenizer.
package stt_pkg;

    localparam int KindBits = 6;
    localparam int MaxTok   = 4;

    typedef logic [KindBits-1:0] t_kind;

    localparam t_kind K_COLON  = 6'd0;
    localparam t_kind K_SEMI   = 6'd1;
    localparam t_kind K_LPAR   = 6'd2;
    localparam t_kind K_RPAR   = 6'd3;
    localparam t_kind K_COMMA  = 6'd4;
    localparam t_kind K_LBRC   = 6'd5;
    localparam t_kind K_RBRC   = 6'd6;
    localparam t_kind K_PLUS   = 6'd7;
    localparam t_kind K_MINUS  = 6'd8;
    localparam t_kind K_STAR   = 6'd9;
    localparam t_kind K_SLASH  = 6'd10;
    localparam t_kind K_AMP    = 6'd11;
    localparam t_kind K_PIPE   = 6'd12;
    localparam t_kind K_EQEQ   = 6'd13;
    localparam t_kind K_BANGEQ = 6'd14;
    localparam t_kind K_BANG   = 6'd15;
    localparam t_kind K_LSHIFT = 6'd16;
    localparam t_kind K_LTE    = 6'd17;
    localparam t_kind K_LT     = 6'd18;
    localparam t_kind K_GTE    = 6'd19;
    localparam t_kind K_GT     = 6'd20;
    localparam t_kind K_KW0    = 6'd21;
    localparam t_kind K_ID     = 6'd37;
    localparam t_kind K_INT    = 6'd38;
    localparam t_kind K_STR    = 6'd39;
    localparam t_kind K_SEC0   = 6'd40;
    localparam t_kind K_EOF    = 6'd43;
    localparam t_kind K_ERR    = 6'd44;
    localparam t_kind K_NONE   = 6'd63;

    // Scanner modes, one-hot.
    typedef enum logic [11:0] {
        M_IDLE    = 12'b000000000001,
        M_SLASH   = 12'b000000000010,
        M_COMMENT = 12'b000000000100,
        M_LT      = 12'b000000001000,
        M_BLOCK   = 12'b000000010000,
        M_SECTION = 12'b000000100000,
        M_IDENT   = 12'b000001000000,
        M_NUMBER  = 12'b000010000000,
        M_STRING  = 12'b000100000000,
        M_EQ      = 12'b001000000000,
        M_BANG    = 12'b010000000000,
        M_GT      = 12'b100000000000
    } t_mode;

    // Keyword text, padded with zero bytes, first letter in the low byte.
    function automatic logic [7:0] kw_char(input int unsigned k, input int unsigned i);
        logic [47:0] s;
        case (k)
            0:  s = {24'h0, "rav"};
            1:  s = {24'h0, "tni"};
            2:  s = {24'h0, "rts"};
            3:  s = "labolg";
            4:  s = {32'h0, "fi"};
            5:  s = {16'h0, "file"};
            6:  s = {16'h0, "esle"};
            7:  s = {16'h0, "pool"};
            8:  s = {8'h0, "poolu"};
            9:  s = {8'h0, "kaerb"};
            10: s = {16'h0, "pmuj"};
            11: s = {24'h0, "lip"};
            12: s = {24'h0, "nic"};
            13: s = {24'h0, "dna"};
            14: s = {32'h0, "ro"};
            default: s = {24'h0, "ton"};
        endcase
        kw_char = (i < 6) ? s[8*i +: 8] : 8'h00;
    endfunction

    function automatic logic [2:0] kw_len(input int unsigned k);
        case (k)
            3: kw_len = 3'd6;
            4, 14: kw_len = 3'd2;
            5, 6, 7, 10: kw_len = 3'd4;
            8, 9: kw_len = 3'd5;
            default: kw_len = 3'd3;
        endcase
    endfunction

    function automatic logic [7:0] sec_char(input int unsigned k, input int unsigned i);
        logic [39:0] s;
        case (k)
            0: s = {8'h0, "atad"};
            1: s = "trats";
            default: s = {16'h0, "dne"};
        endcase
        sec_char = (i < 5) ? s[8*i +: 8] : 8'h00;
    endfunction

    function automatic logic [2:0] sec_len(input int unsigned k);
        case (k)
            0: sec_len = 3'd4;
            1: sec_len = 3'd5;
            default: sec_len = 3'd3;
        endcase
    endfunction

    // Text of the open marker "<begin>" and close marker "<end>".
    function automatic logic [7:0] open_char(input logic [2:0] i);
        case (i)
            3'd0: open_char = "<";
            3'd1: open_char = "b";
            3'd2: open_char = "e";
            3'd3: open_char = "g";
            3'd4: open_char = "i";
            3'd5: open_char = "n";
            3'd6: open_char = ">";
            default: open_char = 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] close_char(input logic [2:0] i);
        case (i)
            3'd0: close_char = "<";
            3'd1: close_char = "e";
            3'd2: close_char = "n";
            3'd3: close_char = "d";
            3'd4: close_char = ">";
            default: close_char = 8'h00;
        endcase
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        is_space = (c == 8'h20) || (c >= 8'd9 && c <= 8'd13);
    endfunction
    function automatic logic is_digit(input logic [7:0] c);
        is_digit = (c >= "0") && (c <= "9");
    endfunction
    function automatic logic is_alpha(input logic [7:0] c);
        is_alpha = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic t_kind punct_kind(input logic [7:0] c);
        case (c)
            ":": punct_kind = K_COLON;
            ";": punct_kind = K_SEMI;
            "(": punct_kind = K_LPAR;
            ")": punct_kind = K_RPAR;
            ",": punct_kind = K_COMMA;
            "{": punct_kind = K_LBRC;
            "}": punct_kind = K_RBRC;
            "+": punct_kind = K_PLUS;
            "-": punct_kind = K_MINUS;
            "*": punct_kind = K_STAR;
            "&": punct_kind = K_AMP;
            "|": punct_kind = K_PIPE;
            default: punct_kind = K_NONE;
        endcase
    endfunction

endpackage

// ===== hw/rtl/stt_if.sv =====
// Valid/ready channel interface carrying one word of payload type T.
interface stt_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/source_text_tokenizer_unit.sv =====
// Top level of the source text tokenizer.
// Usage:
//   i_in carries one source byte per word (ch, end_of_source); o_out carries
//   one token per word (kind, offset, length, line, last_result).
//   Each accepted byte is scanned in the cycle it is accepted and its tokens
//   (zero to four) enter an eight-entry registered queue, behind any tokens
//   already waiting there. Input is taken every cycle while the queue has
//   room for a full burst of four, so one byte per cycle is sustained as
//   long as the receiver takes about one token per byte.
//   When the receiver stalls, tokens wait in the queue and ready drops once
//   fewer than four entries are free.
//   i_cfg_we/i_cfg_data set the first line number; it takes effect when the
//   stream state next returns to its start, i.e. after the next EOF.
//   Reset (i_rst_n low, synchronous) empties the queue, returns the scanner
//   to idle at offset zero, and sets the first line register to 1.
module source_text_tokenizer_unit #(
    parameter int OFFSET_BITS = 24,
    parameter int LINE_BITS   = 20
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [LINE_BITS-1:0] i_cfg_data,
    stt_if.sink                  i_in,
    stt_if.source                o_out
);
    import stt_pkg::*;

    localparam int W = 6 + 2*OFFSET_BITS + LINE_BITS;

    logic [LINE_BITS-1:0]   r_first;
    logic                   room;
    logic                   step;
    logic [3:0]             vld;
    logic [6*4-1:0]         kinds;
    logic [OFFSET_BITS*4-1:0] starts, lens;
    logic [LINE_BITS*4-1:0] lines;
    logic [4*(W+1)-1:0]     packed_tok;
    logic [W:0]             q_data;

    // Hold the first line register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_first <= LINE_BITS'(1);
        else if (i_cfg_we) r_first <= i_cfg_data;
    end

    assign i_in.ready = room;
    assign step = i_in.valid && room;

    stt_scan #(.OFFSET_BITS(OFFSET_BITS), .LINE_BITS(LINE_BITS)) u_scan (
        .i_clk, .i_rst_n, .i_step(step),
        .i_ch(i_in.data.ch), .i_last(i_in.data.end_of_source),
        .i_first_line(r_first),
        .o_tok_vld(vld), .o_tok_kind(kinds), .o_tok_start(starts),
        .o_tok_len(lens), .o_tok_line(lines)
    );

    // Mark the final token of the burst.
    always_comb begin
        for (int j = 0; j < 4; j++) begin
            packed_tok[(W+1)*j +: W+1] = {
                kinds[6*j +: 6], starts[OFFSET_BITS*j +: OFFSET_BITS],
                lens[OFFSET_BITS*j +: OFFSET_BITS], lines[LINE_BITS*j +: LINE_BITS],
                vld[j] && (j == 3 || !vld[(j+1)%4])
            };
        end
    end

    stt_queue #(.W(W+1), .DEPTH_BITS(3)) u_queue (
        .i_clk, .i_rst_n, .i_vld(vld), .i_data(packed_tok), .o_room(room),
        .o_valid(o_out.valid), .i_ready(o_out.ready), .o_data(q_data)
    );

    assign o_out.data.token_kind   = q_data[W -: 6];
    assign o_out.data.start_offset = q_data[W-6 -: OFFSET_BITS];
    assign o_out.data.token_length = q_data[W-6-OFFSET_BITS -: OFFSET_BITS];
    assign o_out.data.line_number  = q_data[LINE_BITS:1];
    assign o_out.data.last_result  = q_data[0];

    // A byte is never taken without room for its burst.
    a_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step |-> room) else $error("byte taken without room");
    // An EOF token is always the last of its burst.
    a_eof_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.data.token_kind == K_EOF |-> o_out.data.last_result)
        else $error("eof not last");
    // Last byte always produces at least one token.
    a_eof: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step && i_in.data.end_of_source |-> vld[0]) else $error("no eof");
endmodule

// ===== hw/rtl/stt_scan.sv =====
// Scanner core: one source byte in, up to four tokens out, at most three mode passes per byte.
module stt_scan #(
    parameter int OFFSET_BITS = 24,
    parameter int LINE_BITS   = 20
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  logic [7:0]           i_ch,
    input  logic                 i_last,
    input  logic [LINE_BITS-1:0] i_first_line,
    output logic [3:0]           o_tok_vld,
    output logic [6*4-1:0]       o_tok_kind,
    output logic [OFFSET_BITS*4-1:0] o_tok_start,
    output logic [OFFSET_BITS*4-1:0] o_tok_len,
    output logic [LINE_BITS*4-1:0]   o_tok_line
);
    import stt_pkg::*;

    localparam logic [OFFSET_BITS-1:0] OffMax = '1;
    localparam logic [LINE_BITS-1:0]   LnMax  = '1;

    t_mode                  r_mode, n_mode;
    logic [OFFSET_BITS-1:0] r_off, n_off;
    logic [LINE_BITS-1:0]   r_line, n_line;
    logic [OFFSET_BITS-1:0] r_tstart, n_tstart;
    logic [OFFSET_BITS-1:0] r_tlen, n_tlen;
    logic [15:0]            r_kw, n_kw;
    logic [2:0]             r_sec, n_sec;
    logic [2:0]             r_mm, n_mm;

    // Token list built for this byte.
    logic [2:0] cnt;
    t_kind      e_kind [MaxTok];
    logic [OFFSET_BITS-1:0] e_start [MaxTok];
    logic [OFFSET_BITS-1:0] e_len [MaxTok];
    logic [LINE_BITS-1:0]   e_line [MaxTok];

    function automatic logic [OFFSET_BITS-1:0] inc_o(input logic [OFFSET_BITS-1:0] v);
        inc_o = (v == OffMax) ? v : v + 1'b1;
    endfunction

    // Keyword candidate update for one letter at index idx.
    function automatic logic [15:0] kw_step(input logic [15:0] kw,
                                            input logic [OFFSET_BITS-1:0] idx,
                                            input logic [7:0] c);
        logic [15:0] r;
        r = kw;
        for (int i = 0; i < 16; i++) begin
            if (idx >= OFFSET_BITS'(kw_len(i)) || kw_char(i, idx[2:0]) != c || idx > 7)
                r[i] = 1'b0;
        end
        kw_step = r;
    endfunction

    function automatic t_kind id_kind(input logic [15:0] kw,
                                      input logic [OFFSET_BITS-1:0] len);
        t_kind k;
        k = K_ID;
        for (int i = 0; i < 16; i++) begin
            if (kw[i] && len == OFFSET_BITS'(kw_len(i)))
                k = K_KW0 + t_kind'(i);
        end
        id_kind = k;
    endfunction

    always_comb begin
        logic [7:0] c;
        logic       again;
        logic [2:0] m;
        logic [OFFSET_BITS-1:0] idx;
        logic       hit;
        c = i_ch;
        m = '0;
        idx = '0;
        hit = 1'b0;
        n_mode = r_mode;
        n_off = r_off;
        n_line = r_line;
        n_tstart = r_tstart;
        n_tlen = r_tlen;
        n_kw = r_kw;
        n_sec = r_sec;
        n_mm = r_mm;
        cnt = '0;
        for (int j = 0; j < MaxTok; j++) begin
            e_kind[j] = K_NONE;
            e_start[j] = '0;
            e_len[j] = '0;
            e_line[j] = '0;
        end
        again = 1'b1;
        // Run the mode machine, at most three passes per byte.
        for (int p = 0; p < 3; p++) begin
            if (again) begin
                again = 1'b0;
                case (n_mode)
                    M_SLASH: begin
                        if (c == "/") n_mode = M_COMMENT;
                        else begin
                            e_kind[cnt[1:0]] = K_SLASH; e_start[cnt[1:0]] = n_tstart;
                            e_len[cnt[1:0]] = OFFSET_BITS'(1); cnt = cnt + 1'b1;
                            n_mode = M_IDLE; again = 1'b1;
                        end
                    end
                    M_COMMENT: if (c == 8'h0A) n_mode = M_IDLE;
                    M_LT: begin
                        if (n_mm < 3'd7 && c == open_char(n_mm)) begin
                            n_mm = n_mm + 1'b1;
                            if (n_mm == 3'd7) begin n_mode = M_BLOCK; n_mm = '0; end
                        end else if (n_mm <= 3'd1) begin
                            n_mode = M_IDLE;
                            e_start[cnt[1:0]] = n_tstart;
                            if (c == "<") begin
                                e_kind[cnt[1:0]] = K_LSHIFT; e_len[cnt[1:0]] = OFFSET_BITS'(2);
                            end else if (c == "=") begin
                                e_kind[cnt[1:0]] = K_LTE; e_len[cnt[1:0]] = OFFSET_BITS'(2);
                            end else begin
                                e_kind[cnt[1:0]] = K_LT; e_len[cnt[1:0]] = OFFSET_BITS'(1);
                                again = 1'b1;
                            end
                            cnt = cnt + 1'b1;
                        end else begin
                            // Replay the matched letters as an identifier.
                            e_kind[cnt[1:0]] = K_LT; e_start[cnt[1:0]] = n_tstart;
                            e_len[cnt[1:0]] = OFFSET_BITS'(1); cnt = cnt + 1'b1;
                            m = n_mm;
                            n_tstart = inc_o(n_tstart);
                            n_tlen = '0;
                            n_kw = '1;
                            n_mode = M_IDENT;
                            for (int i = 1; i < 6; i++) begin
                                if (i < m) begin
                                    n_kw = kw_step(n_kw, n_tlen, open_char(3'(i)));
                                    n_tlen = inc_o(n_tlen);
                                end
                            end
                            again = 1'b1;
                        end
                    end
                    M_BLOCK: begin
                        if (n_mm < 3'd5 && c == close_char(n_mm)) begin
                            n_mm = n_mm + 1'b1;
                            if (n_mm == 3'd5) begin n_mode = M_IDLE; n_mm = '0; end
                        end else n_mm = (c == "<") ? 3'd1 : 3'd0;
                    end
                    M_SECTION: begin
                        if (is_alpha(c) || is_digit(c)) begin
                            idx = n_tlen - 1'b1;
                            for (int i = 0; i < 3; i++)
                                if (idx >= OFFSET_BITS'(sec_len(i)) || idx > 7
                                    || sec_char(i, idx[2:0]) != c)
                                    n_sec[i] = 1'b0;
                            n_tlen = inc_o(n_tlen);
                        end else begin
                            hit = 1'b0;
                            for (int i = 0; i < 3; i++) begin
                                if (!hit && n_sec[i]
                                    && n_tlen - 1'b1 == OFFSET_BITS'(sec_len(i))) begin
                                    hit = 1'b1;
                                    e_kind[cnt[1:0]] = K_SEC0 + t_kind'(i);
                                end
                            end
                            if (hit) begin
                                e_start[cnt[1:0]] = n_tstart; e_len[cnt[1:0]] = n_tlen;
                                cnt = cnt + 1'b1;
                            end
                            n_mode = M_IDLE; again = 1'b1;
                        end
                    end
                    M_IDENT: begin
                        if (is_alpha(c) || is_digit(c) || c == "_") begin
                            n_kw = kw_step(n_kw, n_tlen, c);
                            n_tlen = inc_o(n_tlen);
                        end else begin
                            e_kind[cnt[1:0]] = id_kind(n_kw, n_tlen);
                            e_start[cnt[1:0]] = n_tstart; e_len[cnt[1:0]] = n_tlen;
                            cnt = cnt + 1'b1;
                            n_mode = M_IDLE; again = 1'b1;
                        end
                    end
                    M_NUMBER: begin
                        if (is_digit(c)) n_tlen = inc_o(n_tlen);
                        else begin
                            e_kind[cnt[1:0]] = K_INT;
                            e_start[cnt[1:0]] = n_tstart; e_len[cnt[1:0]] = n_tlen;
                            cnt = cnt + 1'b1;
                            n_mode = M_IDLE; again = 1'b1;
                        end
                    end
                    M_STRING: begin
                        if (c == "\"") begin
                            e_kind[cnt[1:0]] = K_STR;
                            e_start[cnt[1:0]] = n_tstart; e_len[cnt[1:0]] = n_tlen;
                            cnt = cnt + 1'b1;
                            n_mode = M_IDLE;
                        end else n_tlen = inc_o(n_tlen);
                    end
                    M_EQ, M_BANG, M_GT: begin
                        e_start[cnt[1:0]] = n_tstart;
                        if (c == "=") begin
                            e_kind[cnt[1:0]] = (n_mode == M_EQ) ? K_EQEQ :
                                               (n_mode == M_BANG) ? K_BANGEQ : K_GTE;
                            e_len[cnt[1:0]] = OFFSET_BITS'(2);
                        end else begin
                            e_kind[cnt[1:0]] = (n_mode == M_EQ) ? K_ERR :
                                               (n_mode == M_BANG) ? K_BANG : K_GT;
                            e_len[cnt[1:0]] = OFFSET_BITS'(1);
                            again = 1'b1;
                        end
                        cnt = cnt + 1'b1;
                        n_mode = M_IDLE;
                    end
                    default: begin
                        n_mode = M_IDLE;
                        n_tstart = r_off;
                        n_tlen = '0;
                        if (is_space(c)) begin
                        end else if (c == "/") n_mode = M_SLASH;
                        else if (c == "<") begin n_mode = M_LT; n_mm = 3'd1; end
                        else if (c == ".") begin
                            n_mode = M_SECTION; n_tlen = OFFSET_BITS'(1); n_sec = '1;
                        end else if (c == "=") n_mode = M_EQ;
                        else if (c == "!") n_mode = M_BANG;
                        else if (c == ">") n_mode = M_GT;
                        else if (c == "\"") begin
                            n_mode = M_STRING; n_tstart = inc_o(r_off);
                        end else if (is_alpha(c) || c == "_") begin
                            n_mode = M_IDENT;
                            n_kw = kw_step(16'hFFFF, '0, c);
                            n_tlen = OFFSET_BITS'(1);
                        end else if (is_digit(c)) begin
                            n_mode = M_NUMBER; n_tlen = OFFSET_BITS'(1);
                        end else if (punct_kind(c) != K_NONE) begin
                            e_kind[cnt[1:0]] = punct_kind(c);
                            e_start[cnt[1:0]] = r_off; e_len[cnt[1:0]] = OFFSET_BITS'(1);
                            cnt = cnt + 1'b1;
                        end
                    end
                endcase
            end
        end
        // Tokens formed by the passes carry the line count before this byte.
        for (int j = 0; j < MaxTok; j++) e_line[j] = r_line;
        if (c == 8'h0A) n_line = (n_line == LnMax) ? n_line : n_line + 1'b1;
        n_off = inc_o(r_off);
        // Flush the pending token and close with EOF on the last byte, if a slot is left.
        if (i_last) begin
            case (n_mode)
                M_SLASH, M_EQ, M_BANG, M_GT: begin
                    e_kind[cnt[1:0]] = (n_mode == M_SLASH) ? K_SLASH :
                                       (n_mode == M_EQ) ? K_ERR :
                                       (n_mode == M_BANG) ? K_BANG : K_GT;
                    e_start[cnt[1:0]] = n_tstart; e_len[cnt[1:0]] = OFFSET_BITS'(1);
                    e_line[cnt[1:0]] = n_line; cnt = cnt + 1'b1;
                end
                M_LT: begin
                    e_kind[cnt[1:0]] = K_LT; e_start[cnt[1:0]] = n_tstart;
                    e_len[cnt[1:0]] = OFFSET_BITS'(1); e_line[cnt[1:0]] = n_line;
                    cnt = cnt + 1'b1;
                    if (n_mm > 3'd1) begin
                        m = n_mm;
                        n_tstart = inc_o(n_tstart);
                        n_tlen = '0;
                        n_kw = '1;
                        for (int i = 1; i < 6; i++) begin
                            if (i < m) begin
                                n_kw = kw_step(n_kw, n_tlen, open_char(3'(i)));
                                n_tlen = inc_o(n_tlen);
                            end
                        end
                        e_kind[cnt[1:0]] = id_kind(n_kw, n_tlen);
                        e_start[cnt[1:0]] = n_tstart; e_len[cnt[1:0]] = n_tlen;
                        e_line[cnt[1:0]] = n_line; cnt = cnt + 1'b1;
                    end
                end
                M_SECTION: begin
                    hit = 1'b0;
                    for (int i = 0; i < 3; i++) begin
                        if (!hit && n_sec[i] && n_tlen - 1'b1 == OFFSET_BITS'(sec_len(i))) begin
                            hit = 1'b1;
                            e_kind[cnt[1:0]] = K_SEC0 + t_kind'(i);
                        end
                    end
                    if (hit) begin
                        e_start[cnt[1:0]] = n_tstart; e_len[cnt[1:0]] = n_tlen;
                        e_line[cnt[1:0]] = n_line; cnt = cnt + 1'b1;
                    end
                end
                M_IDENT, M_NUMBER, M_STRING: begin
                    e_kind[cnt[1:0]] = (n_mode == M_IDENT) ? id_kind(n_kw, n_tlen) :
                                       (n_mode == M_NUMBER) ? K_INT : K_STR;
                    e_start[cnt[1:0]] = n_tstart; e_len[cnt[1:0]] = n_tlen;
                    e_line[cnt[1:0]] = n_line; cnt = cnt + 1'b1;
                end
                default: begin
                end
            endcase
            if (cnt < 3'd4) begin
                e_kind[cnt[1:0]] = K_EOF; e_start[cnt[1:0]] = n_off;
                e_len[cnt[1:0]] = '0; e_line[cnt[1:0]] = n_line;
                cnt = cnt + 1'b1;
            end
            n_mode = M_IDLE;
            n_off = '0;
            n_line = i_first_line;
            n_tstart = '0;
            n_tlen = '0;
            n_kw = '1;
            n_sec = '1;
            n_mm = '0;
        end
    end

    // Pack the token list for the output queue.
    always_comb begin
        for (int j = 0; j < MaxTok; j++) begin
            o_tok_vld[j] = i_step && (cnt > 3'(j));
            o_tok_kind[6*j +: 6] = e_kind[j];
            o_tok_start[OFFSET_BITS*j +: OFFSET_BITS] = e_start[j];
            o_tok_len[OFFSET_BITS*j +: OFFSET_BITS] = e_len[j];
            o_tok_line[LINE_BITS*j +: LINE_BITS] = e_line[j];
        end
    end

    // Advance scanner state on each accepted byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE;
            r_off <= '0;
            r_line <= LINE_BITS'(1);
            r_tstart <= '0;
            r_tlen <= '0;
            r_kw <= '1;
            r_sec <= '1;
            r_mm <= '0;
        end else if (i_step) begin
            r_mode <= n_mode;
            r_off <= n_off;
            r_line <= n_line;
            r_tstart <= n_tstart;
            r_tlen <= n_tlen;
            r_kw <= n_kw;
            r_sec <= n_sec;
            r_mm <= n_mm;
        end
    end
endmodule

// ===== hw/rtl/stt_queue.sv =====
// Token queue: takes up to four tokens a cycle, hands out one per cycle while ready.
module stt_queue #(
    parameter int W = 75,
    parameter int DEPTH_BITS = 3
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [3:0]    i_vld,
    input  logic [4*W-1:0] i_data,
    output logic          o_room,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [W-1:0]  o_data
);
    localparam int Depth = 1 << DEPTH_BITS;

    logic [W-1:0]        r_mem [Depth];
    logic [DEPTH_BITS-1:0] r_rd, r_wr;
    logic [DEPTH_BITS:0] r_cnt;
    logic [2:0]          push_n;
    logic                pop;

    assign push_n = 3'(i_vld[0]) + 3'(i_vld[1]) + 3'(i_vld[2]) + 3'(i_vld[3]);
    assign pop = o_valid && i_ready;
    assign o_valid = (r_cnt != '0);
    assign o_data = r_mem[r_rd];
    // Room for a full burst of four, judged on the count before this cycle's pop.
    assign o_room = (r_cnt <= (DEPTH_BITS+1)'(Depth - 4));

    // Store the burst in order.
    always_ff @(posedge i_clk) begin
        for (int j = 0; j < 4; j++)
            if (i_vld[j]) r_mem[r_wr + DEPTH_BITS'(j)] <= i_data[W*j +: W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd <= '0;
            r_wr <= '0;
            r_cnt <= '0;
        end else begin
            r_wr <= r_wr + DEPTH_BITS'(push_n);
            if (pop) r_rd <= r_rd + 1'b1;
            r_cnt <= r_cnt + (DEPTH_BITS+1)'(push_n) - (DEPTH_BITS+1)'(pop);
        end
    end
endmodule

// ===== tb/source_text_tokenizer_unit_tb.sv =====
// Testbench of the source text tokenizer: directed and random byte streams checked against a token predictor.
module source_text_tokenizer_unit_tb;
    import stt_pkg::*;

    typedef struct packed {
        logic [7:0] ch;
        logic       end_of_source;
    } t_byte_word;

    typedef struct packed {
        t_kind       token_kind;
        logic [23:0] start_offset;
        logic [23:0] token_length;
        logic [19:0] line_number;
        logic        last_result;
    } t_tok_word;

    localparam int    IdleLimit = 4000;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [19:0] i_cfg_data;

    stt_if #(.T(t_byte_word)) in_ch ();
    stt_if #(.T(t_tok_word))  out_ch ();

    source_text_tokenizer_unit u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch.sink),
        .o_out      (out_ch.source)
    );

    // Clock
    always begin
        i_clk = 1'b1; #1;
        i_clk = 1'b0; #1;
    end

    // Scanner copy
    string kw_txt [16] = '{"var", "int", "str", "global", "if", "elif", "else", "loop",
                           "uloop", "break", "jump", "pil", "cin", "and", "or", "not"};
    string sec_txt [3] = '{"data", "start", "end"};
    string open_txt = "<begin>";
    string close_txt = "<end>";

    logic [19:0] line_base;
    t_mode       mode;
    logic [23:0] boff, tstart, tlen;
    logic [19:0] lcnt;
    logic [15:0] kw_cand;
    logic [2:0]  sec_cand;
    logic [2:0]  mark_cnt;

    t_tok_word burst [$];
    t_tok_word tok_expect [$];
    t_byte_word byte_q [$];
    int err_cnt = 0;

    function automatic logic [23:0] sat24(logic [23:0] v);
        return (v == '1) ? v : v + 24'd1;
    endfunction

    function automatic void scanner_clear();
        mode = M_IDLE;
        boff = '0;
        lcnt = line_base;
        tstart = '0;
        tlen = '0;
        kw_cand = '1;
        sec_cand = '1;
        mark_cnt = '0;
    endfunction

    function automatic void put_tok(t_kind k, logic [23:0] s, logic [23:0] l);
        t_tok_word w;
        if (burst.size() < MaxTok) begin
            w.token_kind = k;
            w.start_offset = s;
            w.token_length = l;
            w.line_number = lcnt;
            w.last_result = 1'b0;
            burst = {burst, w};
        end
    endfunction

    function automatic bit is_alnum_c(logic [7:0] c);
        return ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || (c >= "0" && c <= "9"));
    endfunction

    function automatic void ident_feed(logic [7:0] c);
        for (int i = 0; i < 16; i++)
            if (tlen >= kw_txt[i].len() || kw_txt[i][tlen] != c) kw_cand[i] = 1'b0;
        tlen = sat24(tlen);
    endfunction

    function automatic void ident_out();
        t_kind k;
        k = K_ID;
        for (int i = 0; i < 16; i++)
            if (kw_cand[i] && tlen == kw_txt[i].len()) k = K_KW0 + t_kind'(i);
        put_tok(k, tstart, tlen);
    endfunction

    function automatic void sect_feed(logic [7:0] c);
        logic [23:0] idx;
        idx = tlen - 24'd1;
        for (int i = 0; i < 3; i++)
            if (idx >= sec_txt[i].len() || sec_txt[i][idx] != c) sec_cand[i] = 1'b0;
        tlen = sat24(tlen);
    endfunction

    function automatic void sect_out();
        for (int i = 0; i < 3; i++)
            if (sec_cand[i] && tlen - 24'd1 == sec_txt[i].len()) begin
                put_tok(K_SEC0 + t_kind'(i), tstart, tlen);
                return;
            end
    endfunction

    // Partial begin marker: emit '<', restart as identifier from matched letters
    function automatic void lt_split();
        int m;
        m = (mark_cnt < 7) ? mark_cnt : 6;
        put_tok(K_LT, tstart, 24'd1);
        tstart = sat24(tstart);
        tlen = '0;
        kw_cand = '1;
        mode = M_IDENT;
        for (int i = 1; i < m; i++) ident_feed(open_txt[i]);
    endfunction

    function automatic void idle_char(logic [7:0] c);
        mode = M_IDLE;
        tstart = boff;
        tlen = '0;
        if (c == 8'h20 || (c >= 8'd9 && c <= 8'd13)) return;
        case (c)
            "/": mode = M_SLASH;
            "<": begin mode = M_LT; mark_cnt = 3'd1; end
            ".": begin mode = M_SECTION; tlen = 24'd1; sec_cand = '1; end
            "=": mode = M_EQ;
            "!": mode = M_BANG;
            ">": mode = M_GT;
            "\"": begin mode = M_STRING; tstart = sat24(boff); end
            ":": put_tok(K_COLON, boff, 24'd1);
            ";": put_tok(K_SEMI, boff, 24'd1);
            "(": put_tok(K_LPAR, boff, 24'd1);
            ")": put_tok(K_RPAR, boff, 24'd1);
            ",": put_tok(K_COMMA, boff, 24'd1);
            "{": put_tok(K_LBRC, boff, 24'd1);
            "}": put_tok(K_RBRC, boff, 24'd1);
            "+": put_tok(K_PLUS, boff, 24'd1);
            "-": put_tok(K_MINUS, boff, 24'd1);
            "*": put_tok(K_STAR, boff, 24'd1);
            "&": put_tok(K_AMP, boff, 24'd1);
            "|": put_tok(K_PIPE, boff, 24'd1);
            default: begin
                if ((c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_") begin
                    mode = M_IDENT;
                    kw_cand = '1;
                    ident_feed(c);
                end else if (c >= "0" && c <= "9") begin
                    mode = M_NUMBER;
                    tlen = 24'd1;
                end
            end
        endcase
    endfunction

    // Returns 1 when the byte must be scanned again in the new mode
    function automatic bit scan_char(logic [7:0] c);
        case (mode)
            M_SLASH: begin
                if (c == "/") begin mode = M_COMMENT; return 0; end
                put_tok(K_SLASH, tstart, 24'd1);
                mode = M_IDLE;
                return 1;
            end
            M_COMMENT: begin
                if (c == 8'h0A) mode = M_IDLE;
                return 0;
            end
            M_LT: begin
                if (mark_cnt < 7 && c == open_txt[mark_cnt]) begin
                    mark_cnt = mark_cnt + 3'd1;
                    if (mark_cnt >= 7) begin mode = M_BLOCK; mark_cnt = '0; end
                    return 0;
                end
                if (mark_cnt <= 1) begin
                    mode = M_IDLE;
                    if (c == "<") begin put_tok(K_LSHIFT, tstart, 24'd2); return 0; end
                    if (c == "=") begin put_tok(K_LTE, tstart, 24'd2); return 0; end
                    put_tok(K_LT, tstart, 24'd1);
                    return 1;
                end
                lt_split();
                return 1;
            end
            M_BLOCK: begin
                if (mark_cnt < 5 && c == close_txt[mark_cnt]) begin
                    mark_cnt = mark_cnt + 3'd1;
                    if (mark_cnt >= 5) begin mode = M_IDLE; mark_cnt = '0; end
                end else begin
                    mark_cnt = (c == "<") ? 3'd1 : 3'd0;
                end
                return 0;
            end
            M_SECTION: begin
                if (is_alnum_c(c)) begin sect_feed(c); return 0; end
                sect_out();
                mode = M_IDLE;
                return 1;
            end
            M_IDENT: begin
                if (is_alnum_c(c) || c == "_") begin ident_feed(c); return 0; end
                ident_out();
                mode = M_IDLE;
                return 1;
            end
            M_NUMBER: begin
                if (c >= "0" && c <= "9") begin tlen = sat24(tlen); return 0; end
                put_tok(K_INT, tstart, tlen);
                mode = M_IDLE;
                return 1;
            end
            M_STRING: begin
                if (c == "\"") begin put_tok(K_STR, tstart, tlen); mode = M_IDLE; end
                else tlen = sat24(tlen);
                return 0;
            end
            M_EQ, M_BANG, M_GT: begin
                t_mode was;
                was = mode;
                mode = M_IDLE;
                if (c == "=") begin
                    put_tok((was == M_EQ) ? K_EQEQ : (was == M_BANG) ? K_BANGEQ : K_GTE,
                            tstart, 24'd2);
                    return 0;
                end
                put_tok((was == M_EQ) ? K_ERR : (was == M_BANG) ? K_BANG : K_GT,
                        tstart, 24'd1);
                return 1;
            end
            default: begin
                idle_char(c);
                return 0;
            end
        endcase
    endfunction

    // Resolve a pending token at end of source
    function automatic void flush_pending();
        case (mode)
            M_SLASH: put_tok(K_SLASH, tstart, 24'd1);
            M_LT: begin
                if (mark_cnt <= 1) put_tok(K_LT, tstart, 24'd1);
                else begin lt_split(); ident_out(); end
            end
            M_SECTION: sect_out();
            M_IDENT: ident_out();
            M_NUMBER: put_tok(K_INT, tstart, tlen);
            M_STRING: put_tok(K_STR, tstart, tlen);
            M_EQ: put_tok(K_ERR, tstart, 24'd1);
            M_BANG: put_tok(K_BANG, tstart, 24'd1);
            M_GT: put_tok(K_GT, tstart, 24'd1);
            default: ;
        endcase
    endfunction

    function automatic void predict_tokens(t_byte_word w);
        burst.delete();
        for (int p = 0; p < 3; p++)
            if (!scan_char(w.ch)) break;
        if (w.ch == 8'h0A && lcnt != '1) lcnt = lcnt + 20'd1;
        boff = sat24(boff);
        if (w.end_of_source) begin
            flush_pending();
            put_tok(K_EOF, boff, 24'd0);
            scanner_clear();
        end
        if (burst.size() > 0) burst[burst.size()-1].last_result = 1'b1;
        tok_expect = {tok_expect, burst};
    endfunction

    // Stimulus helpers
    task automatic push_byte(logic [7:0] c, bit last);
        t_byte_word w;
        w.ch = c;
        w.end_of_source = last;
        byte_q = {byte_q, w};
    endtask

    task automatic push_src(string s);
        for (int i = 0; i < s.len(); i++) push_byte(s[i], i == s.len() - 1);
    endtask

    function automatic string rand_word();
        string s;
        string alnum;
        alnum = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_";
        s = "";
        for (int i = $urandom_range(0, 5); i >= 0; i--)
            s = {s, string'(alnum[$urandom_range(0, alnum.len() - 1)])};
        return s;
    endfunction

    function automatic string rand_frag();
        string ops [24] = '{":", ";", "(", ")", ",", "{", "}", "+", "-", "*", "/", "&", "|",
                            "==", "!=", "!", "<<", "<=", "<", ">=", ">", "=", "<=", ">"};
        string s;
        logic [7:0] b;
        case ($urandom_range(0, 13))
            0, 1: return kw_txt[$urandom_range(0, 15)];
            2: return {"x", rand_word()};
            3: return $sformatf("%0d", $urandom_range(0, 99999));
            4: return {"\"", rand_word(), " ", rand_word(), "\""};
            5: return {".", sec_txt[$urandom_range(0, 2)]};
            6: return {".", rand_word()};
            7, 8: return ops[$urandom_range(0, 23)];
            9: return {"// ", rand_word(), "\n"};
            10: return {"<begin>", rand_word(), " <en <", rand_word(), "<end>"};
            11: begin
                s = open_txt.substr(0, $urandom_range(1, 5));
                return {s, rand_word()};
            end
            12: begin
                // A string cannot hold a zero byte; that one is sent directly
                b = 8'($urandom_range(1, 255));
                return string'(b);
            end
            default: return ($urandom_range(0, 2) == 0) ? "\n" : " ";
        endcase
    endfunction

    // Driver: bursts with random gaps
    bit in_took;
    int burst_left = 0;
    int gap_left = 0;

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (in_ch.valid && !in_took) begin
            // hold the word until taken
        end else if (gap_left > 0) begin
            in_ch.valid <= 1'b0;
            gap_left <= gap_left - 1;
        end else if (byte_q.size() > 0) begin
            in_ch.data <= byte_q.pop_front();
            in_ch.valid <= 1'b1;
            if (burst_left == 0) begin
                burst_left <= $urandom_range(0, 40);
                gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
            end else begin
                burst_left <= burst_left - 1;
            end
        end else begin
            in_ch.valid <= 1'b0;
        end
    end

    // Receiver stall pattern: rotate between free, random and periodic
    int rx_cyc = 0;
    always @(negedge i_clk) begin
        rx_cyc <= rx_cyc + 1;
        case ((rx_cyc / 300) % 3)
            0: out_ch.ready <= 1'b1;
            1: out_ch.ready <= ($urandom_range(0, 1) == 1);
            default: out_ch.ready <= (rx_cyc % 8) < 5;
        endcase
    end

    // Monitor and watchdog
    int idle_cyc = 0;
    always @(posedge i_clk) begin
        t_tok_word want, got;
        in_took = i_rst_n && in_ch.valid && in_ch.ready;
        if (in_took) predict_tokens(in_ch.data);
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got = out_ch.data;
            if (tok_expect.size() == 0) begin
                $error("unexpected token word kind %0d", got.token_kind);
                err_cnt++;
            end else begin
                want = tok_expect.pop_front();
                if (got.token_kind !== want.token_kind) begin
                    $error("token_kind exp %0d got %0d", want.token_kind, got.token_kind);
                    err_cnt++;
                end
                if (got.start_offset !== want.start_offset) begin
                    $error("start_offset exp %0d got %0d", want.start_offset, got.start_offset);
                    err_cnt++;
                end
                if (got.token_length !== want.token_length) begin
                    $error("token_length exp %0d got %0d", want.token_length, got.token_length);
                    err_cnt++;
                end
                if (got.line_number !== want.line_number) begin
                    $error("line_number exp %0d got %0d", want.line_number, got.line_number);
                    err_cnt++;
                end
                if (got.last_result !== want.last_result) begin
                    $error("last_result exp %0d got %0d", want.last_result, got.last_result);
                    err_cnt++;
                end
            end
        end
        if (in_took || (out_ch.valid && out_ch.ready)) idle_cyc <= 0;
        else idle_cyc <= idle_cyc + 1;
        if (idle_cyc >= IdleLimit) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Wait until the block has drained, then write the first line register
    task automatic write_line_base(logic [19:0] v);
        while (byte_q.size() > 0 || in_ch.valid || tok_expect.size() > 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= v;
        line_base = v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        int n;
        string src;
        logic [19:0] bases [4];
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
        line_base = 20'd1;
        scanner_clear();
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed sources
        push_src("uloop x_1 07 \"ab\".end .foo <= << == != ! >= > =");
        push_src("<beg1 <b <begin> q <end>// c\n/ :;(),{}+-*&|\"op");
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'h80, 1'b0);
        push_src({"@.data", "\n", ".start ="});
        push_src("<bexyz <be");

        bases = '{20'd0, 20'hFFFFF, 20'd1, 20'd0};
        bases[3] = $urandom_range(2, 20'hFFFFE);
        foreach (bases[k]) begin
            write_line_base(bases[k]);
            n = 0;
            while (n < 85) begin
                src = "";
                for (int f = $urandom_range(1, 12); f > 0; f--) begin
                    src = {src, rand_frag()};
                    if ($urandom_range(0, 2) != 0) src = {src, " "};
                end
                n += src.len();
                push_src(src);
            end
        end
        // Write between sources, effective after the trailing end of source
        write_line_base(20'd7);
        push_src("a\nb\n");
        push_src("c\n\"open");

        while (byte_q.size() > 0 || in_ch.valid || tok_expect.size() > 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        if (err_cnt == 0 && tok_expect.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
